/* design/sm3_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_pkg
// Shared constants, control struct and round helper functions for the SM3 core.
// ----------------------------------------------------------------------------
package sm3_pkg;

    localparam logic [31:0] C_SM3_IV [0:7] = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    localparam logic [31:0] C_TJ_LOW  = 32'h79cc4519;
    localparam logic [31:0] C_TJ_HIGH = 32'h7a879d8a;
    localparam logic [7:0]  C_PAD_BYTE = 8'h80;

    typedef struct packed {
        logic       start;
        logic       reload;
        logic       wr_en;
        logic [3:0] wr_idx;
    } t_cmp_ctrl;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
    endfunction

    function automatic logic [31:0] tj_rot(input logic [5:0] j);
        logic [31:0] t;
        t = (j < 6'd16) ? C_TJ_LOW : C_TJ_HIGH;
        return rotl32(t, j[4:0]);
    endfunction

endpackage
`default_nettype wire

/* design/sm3_compress.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_compress
// One-round-per-cycle SM3 compression with a shifting message expansion window.
// ----------------------------------------------------------------------------
module sm3_compress
    import sm3_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmp_ctrl        i_ctrl,
    input  wire logic [31:0]      i_wr_data,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [7:0][31:0]      o_chain
);

    logic [31:0]       r_win [0:15];
    logic [31:0]       r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [7:0][31:0]  r_chain;
    logic              r_busy;
    logic [6:0]        r_round;

    logic              run;
    logic [31:0]       a12, ss1, ss2, ff, gg, tt1, tt2, w_new;

    assign run    = r_busy && !r_round[6];
    assign o_busy = r_busy;
    assign o_done = r_busy && r_round[6];
    assign o_chain = r_chain;

    always_comb begin
        a12 = rotl32(r_a, 5'd12);
        ss1 = rotl32(a12 + r_e + tj_rot(r_round[5:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (r_round[6:4] == 3'd0) begin
            ff = r_a ^ r_b ^ r_c;
            gg = r_e ^ r_f ^ r_g;
        end else begin
            ff = (r_a & r_b) | (r_a & r_c) | (r_b & r_c);
            gg = (r_e & r_f) | (~r_e & r_g);
        end
        tt1 = ff + r_d + ss2 + (r_win[0] ^ r_win[4]);
        tt2 = gg + r_h + ss1 + r_win[0];
        w_new = perm1(r_win[0] ^ r_win[7] ^ rotl32(r_win[13], 5'd15))
              ^ rotl32(r_win[3], 5'd7) ^ r_win[10];
    end

    // control and chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= '0;
            for (int i = 0; i < 8; i++) r_chain[i] <= C_SM3_IV[i];
        end else begin
            if (i_ctrl.start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                if (r_round[6]) begin
                    r_busy  <= 1'b0;
                    r_round <= '0;
                end else begin
                    r_round <= r_round + 7'd1;
                end
            end
            if (i_ctrl.reload) begin
                for (int i = 0; i < 8; i++) r_chain[i] <= C_SM3_IV[i];
            end else if (o_done) begin
                r_chain[0] <= r_chain[0] ^ r_a;
                r_chain[1] <= r_chain[1] ^ r_b;
                r_chain[2] <= r_chain[2] ^ r_c;
                r_chain[3] <= r_chain[3] ^ r_d;
                r_chain[4] <= r_chain[4] ^ r_e;
                r_chain[5] <= r_chain[5] ^ r_f;
                r_chain[6] <= r_chain[6] ^ r_g;
                r_chain[7] <= r_chain[7] ^ r_h;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0; r_b <= '0; r_c <= '0; r_d <= '0;
            r_e <= '0; r_f <= '0; r_g <= '0; r_h <= '0;
        end else if (i_ctrl.start) begin
            r_a <= r_chain[0]; r_b <= r_chain[1]; r_c <= r_chain[2]; r_d <= r_chain[3];
            r_e <= r_chain[4]; r_f <= r_chain[5]; r_g <= r_chain[6]; r_h <= r_chain[7];
        end else if (run) begin
            r_d <= r_c;
            r_c <= rotl32(r_b, 5'd9);
            r_b <= r_a;
            r_a <= tt1;
            r_h <= r_g;
            r_g <= rotl32(r_f, 5'd19);
            r_f <= r_e;
            r_e <= perm0(tt2);
        end
    end

    // expansion window
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_win[i_ctrl.wr_idx] <= i_wr_data;
        end else if (run) begin
            for (int i = 0; i < 15; i++) r_win[i] <= r_win[i + 1];
            r_win[15] <= w_new;
        end
    end

endmodule
`default_nettype wire

/* design/sm3_hash_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_hash_core
// SM3 hash of a byte message delivered as big-endian 32-bit words.
// ----------------------------------------------------------------------------
// input channel: i_valid / o_ready with i_data_word, i_valid_bytes, i_final_word.
// a non-final word carries four bytes; the sixteenth word of a block starts a
// compression (one round per cycle in the shared round unit plus the chaining
// fold), during which o_ready is low. the sustained word rate is set by the
// 64 rounds and the fold per block.
// the final word carries 0 to 4 bytes; padding words are written one per cycle,
// followed by one or two compressions, after which the digest is presented.
// output channel: o_valid / i_ready with o_digest_word, o_digest_index and
// o_digest_last; eight requests V0..V7, one per cycle when i_ready is high.
// a stalled receiver simply holds the current digest word; no input is taken
// until the eighth word is delivered, then the chaining value reloads the IV.
// reset is synchronous active low and returns the block to the initial vector
// with an empty message.
// ----------------------------------------------------------------------------
module sm3_hash_core
    import sm3_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_data_word,
    input  wire logic [2:0]  i_valid_bytes,
    input  wire logic        i_final_word,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_digest_index,
    output logic             o_digest_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_COMP = 2'd1;
    localparam logic [1:0] ST_FILL = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]  r_state,   n_state;
    logic [3:0]  r_pos,     n_pos;
    logic [63:0] r_bitlen,  n_bitlen;
    logic        r_final,   n_final;
    logic        r_pend80,  n_pend80;
    logic        r_extra,   n_extra;
    logic [3:0]  r_widx,    n_widx;
    logic [2:0]  r_out_idx, n_out_idx;

    t_cmp_ctrl        cmp_ctrl;
    logic [31:0]      wr_data;
    logic             cmp_busy;
    logic             cmp_done;
    logic [7:0][31:0] chain;

    logic        in_acc, out_acc;
    logic [2:0]  nvalid;
    logic [31:0] fin_word;
    logic [31:0] fill_word;

    assign o_ready        = (r_state == ST_IDLE);
    assign o_valid        = (r_state == ST_OUT);
    assign in_acc         = i_valid && o_ready;
    assign out_acc        = o_valid && i_ready;
    assign o_digest_word  = chain[r_out_idx];
    assign o_digest_index = r_out_idx;
    assign o_digest_last  = (r_out_idx == 3'd7);

    assign nvalid = (i_valid_bytes > 3'd4) ? 3'd4 : i_valid_bytes;

    always_comb begin
        case (nvalid)
            3'd0:    fin_word = {C_PAD_BYTE, 24'd0};
            3'd1:    fin_word = {i_data_word[31:24], C_PAD_BYTE, 16'd0};
            3'd2:    fin_word = {i_data_word[31:16], C_PAD_BYTE, 8'd0};
            3'd3:    fin_word = {i_data_word[31:8], C_PAD_BYTE};
            default: fin_word = i_data_word;
        endcase
    end

    always_comb begin
        if (r_pend80) begin
            fill_word = {C_PAD_BYTE, 24'd0};
        end else if (r_widx == 4'd14 && !r_extra) begin
            fill_word = r_bitlen[63:32];
        end else if (r_widx == 4'd15 && !r_extra) begin
            fill_word = r_bitlen[31:0];
        end else begin
            fill_word = '0;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_bitlen  = r_bitlen;
        n_final   = r_final;
        n_pend80  = r_pend80;
        n_extra   = r_extra;
        n_widx    = r_widx;
        n_out_idx = r_out_idx;
        cmp_ctrl  = '0;
        wr_data   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    cmp_ctrl.wr_en  = 1'b1;
                    cmp_ctrl.wr_idx = r_pos;
                    if (!i_final_word) begin
                        wr_data  = i_data_word;
                        n_bitlen = r_bitlen + 64'd32;
                        n_pos    = r_pos + 4'd1;
                        n_final  = 1'b0;
                        if (r_pos == 4'd15) begin
                            cmp_ctrl.start = 1'b1;
                            n_state        = ST_COMP;
                        end
                    end else begin
                        wr_data  = fin_word;
                        n_bitlen = r_bitlen + {58'd0, nvalid, 3'b000};
                        n_final  = 1'b1;
                        n_pend80 = (nvalid == 3'd4);
                        n_extra  = (nvalid != 3'd4) && (r_pos >= 4'd14);
                        if (r_pos == 4'd15) begin
                            cmp_ctrl.start = 1'b1;
                            n_state        = ST_COMP;
                        end else begin
                            n_widx  = r_pos + 4'd1;
                            n_state = ST_FILL;
                        end
                    end
                end
            end
            ST_FILL: begin
                cmp_ctrl.wr_en  = 1'b1;
                cmp_ctrl.wr_idx = r_widx;
                wr_data         = fill_word;
                if (r_pend80) begin
                    n_pend80 = 1'b0;
                    if (r_widx >= 4'd14) n_extra = 1'b1;
                end
                n_widx = r_widx + 4'd1;
                if (r_widx == 4'd15) begin
                    cmp_ctrl.start = 1'b1;
                    n_state        = ST_COMP;
                end
            end
            ST_COMP: begin
                if (cmp_done) begin
                    if (!r_final) begin
                        n_state = ST_IDLE;
                    end else if (r_pend80 || r_extra) begin
                        n_widx  = '0;
                        n_extra = 1'b0;
                        n_state = ST_FILL;
                    end else begin
                        n_out_idx = '0;
                        n_state   = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    n_out_idx = r_out_idx + 3'd1;
                    if (r_out_idx == 3'd7) begin
                        cmp_ctrl.reload = 1'b1;
                        n_bitlen        = '0;
                        n_pos           = '0;
                        n_final         = 1'b0;
                        n_state         = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pos     <= '0;
            r_bitlen  <= '0;
            r_final   <= 1'b0;
            r_pend80  <= 1'b0;
            r_extra   <= 1'b0;
            r_widx    <= '0;
            r_out_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_bitlen  <= n_bitlen;
            r_final   <= n_final;
            r_pend80  <= n_pend80;
            r_extra   <= n_extra;
            r_widx    <= n_widx;
            r_out_idx <= n_out_idx;
        end
    end

    sm3_compress u_compress (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (cmp_ctrl),
        .i_wr_data (wr_data),
        .o_busy    (cmp_busy),
        .o_done    (cmp_done),
        .o_chain   (chain)
    );

`ifndef SYNTHESIS
    // no digest request while a compression is still folding
    a_out_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !cmp_busy)
        else $error("digest presented during compression");

    // a compression is never restarted while running
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmp_ctrl.start |-> !cmp_busy)
        else $error("compression started while busy");

    // delivering the eighth word returns the block to accepting input
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_digest_last) |=> (o_ready && r_bitlen == 64'd0))
        else $error("block not idle after last digest word");
`endif

endmodule
`default_nettype wire

/* sim/sm3_digest_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3_digest_checker
// Watches the message and digest channels of sm3_hash_core. Every accepted
// message word updates its own SM3 state (bit count, block buffer, chaining
// value); a final word pads, compresses and queues the eight digest words,
// which are then compared field by field against each accepted digest word.
// ----------------------------------------------------------------------------
module sm3_digest_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    input  wire logic        i_req_ready,
    input  wire logic [31:0] i_data_word,
    input  wire logic [2:0]  i_valid_bytes,
    input  wire logic        i_final_word,
    input  wire logic        i_dig_valid,
    input  wire logic        i_dig_ready,
    input  wire logic [31:0] i_digest_word,
    input  wire logic [2:0]  i_digest_index,
    input  wire logic        i_digest_last,
    output int unsigned      o_fail_count,
    output int unsigned      o_pending
);

    localparam logic [31:0] INIT_CHAIN [0:7] = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };
    localparam logic [31:0] T_EARLY  = 32'h79cc4519;
    localparam logic [31:0] T_LATE   = 32'h7a879d8a;
    localparam logic [7:0]  PAD_MARK = 8'h80;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_rec;

    t_digest_rec expected_digest_q [$];

    logic [31:0] chain [0:7];
    logic [31:0] block_buf [0:15];
    logic [63:0] msg_bits;
    logic [3:0]  word_slot;
    int unsigned byte_pos;
    int unsigned fail_total = 0;
    int unsigned pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
        int unsigned s;
        s = n % 32;
        if (s == 0)
            return x;
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic logic [31:0] diffuse0(input logic [31:0] x);
        return x ^ rol(x, 9) ^ rol(x, 17);
    endfunction

    function automatic logic [31:0] diffuse1(input logic [31:0] x);
        return x ^ rol(x, 15) ^ rol(x, 23);
    endfunction

    task automatic fold_block();
        logic [31:0] w [0:67];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj;
        int j;
        for (j = 0; j < 16; j++)
            w[j] = block_buf[j];
        for (j = 16; j < 68; j++)
            w[j] = diffuse1(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (j = 0; j < 64; j++) begin
            tj  = (j < 16) ? T_EARLY : T_LATE;
            a12 = rol(a, 12);
            ss1 = rol(a12 + e + rol(tj, j), 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
                ff = a ^ b ^ c;
                gg = e ^ f ^ g;
            end else begin
                ff = (a & b) | (a & c) | (b & c);
                gg = (e & f) | (~e & g);
            end
            tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
            tt2 = gg + h + ss1 + w[j];
            d = c; c = rol(b, 9); b = a; a = tt1;
            h = g; g = rol(f, 19); f = e; e = diffuse0(tt2);
        end
        chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
        chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
    endtask

    task automatic stash_byte(input logic [7:0] value);
        int unsigned idx;
        int unsigned sh;
        idx = (byte_pos >> 2) & 15;
        sh  = (3 - (byte_pos & 3)) * 8;
        if ((byte_pos & 3) == 0)
            block_buf[idx] = '0;
        block_buf[idx] = block_buf[idx] | (32'(value) << sh);
        byte_pos++;
        if (byte_pos >= 64) begin
            fold_block();
            byte_pos = 0;
        end
    endtask

    task automatic absorb_request(input logic [31:0] data, input logic [2:0] nbytes,
                                  input logic fin);
        int unsigned n;
        int unsigned k;
        t_digest_rec rec;
        if (!fin) begin
            block_buf[word_slot] = data;
            msg_bits  = msg_bits + 64'd32;
            word_slot = word_slot + 4'd1;
            if (word_slot == 4'd0)
                fold_block();
        end else begin
            n = (nbytes > 3'd4) ? 4 : int'(nbytes);
            byte_pos = int'(word_slot) * 4;
            for (k = 0; k < n; k++) begin
                stash_byte(8'(data >> (24 - 8 * k)));
                msg_bits = msg_bits + 64'd8;
            end
            stash_byte(PAD_MARK);
            if (byte_pos > 56) begin
                while (byte_pos != 0)
                    stash_byte(8'h00);
            end
            while (byte_pos < 56)
                stash_byte(8'h00);
            for (k = 0; k < 8; k++)
                stash_byte(8'(msg_bits >> (56 - 8 * k)));
            for (k = 0; k < 8; k++) begin
                rec.word  = chain[k];
                rec.index = 3'(k);
                rec.last  = (k == 7);
                expected_digest_q.push_back(rec);
            end
            for (k = 0; k < 8; k++)
                chain[k] = INIT_CHAIN[k];
            msg_bits  = '0;
            word_slot = '0;
        end
    endtask

    always @(posedge i_clk) begin
        t_digest_rec want;
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++)
                chain[k] = INIT_CHAIN[k];
            for (int k = 0; k < 16; k++)
                block_buf[k] = '0;
            msg_bits  = '0;
            word_slot = '0;
            expected_digest_q.delete();
        end else begin
            if (i_dig_valid && i_dig_ready) begin
                if (expected_digest_q.size() == 0) begin
                    $display("%0t: unexpected digest word %h index %0d last %0d",
                             $time, i_digest_word, i_digest_index, i_digest_last);
                    fail_total++;
                end else begin
                    want = expected_digest_q.pop_front();
                    if (i_digest_word !== want.word) begin
                        $display("%0t: digest_word expected %h actual %h (index %0d)",
                                 $time, want.word, i_digest_word, want.index);
                        fail_total++;
                    end
                    if (i_digest_index !== want.index) begin
                        $display("%0t: digest_index expected %0d actual %0d",
                                 $time, want.index, i_digest_index);
                        fail_total++;
                    end
                    if (i_digest_last !== want.last) begin
                        $display("%0t: digest_last expected %0d actual %0d",
                                 $time, want.last, i_digest_last);
                        fail_total++;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                absorb_request(i_data_word, i_valid_bytes, i_final_word);
        end
        pending_total = expected_digest_q.size();
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte messages into sm3_hash_core as 32-bit words with random idle
// bursts and receiver stalls, including one long receiver hold-off and full
// drains; sm3_digest_checker predicts and compares every digest word.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned TARGET_WORDS   = 460;
    localparam int unsigned QUIET_FROM     = 400;
    localparam int unsigned LONG_HOLD      = 400;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        req_valid     = 1'b0;
    logic [31:0] req_data      = '0;
    logic [2:0]  req_nbytes    = '0;
    logic        req_final     = 1'b0;
    logic        dig_ready     = 1'b0;
    logic        req_ready;
    logic        dig_valid;
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned words_sent  = 0;
    int unsigned idle_cycles = 0;
    bit          quiet_tail  = 1'b0;

    always #1 i_clk = ~i_clk;

    sm3_hash_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (req_valid),
        .o_ready        (req_ready),
        .i_data_word    (req_data),
        .i_valid_bytes  (req_nbytes),
        .i_final_word   (req_final),
        .o_valid        (dig_valid),
        .i_ready        (dig_ready),
        .o_digest_word  (digest_word),
        .o_digest_index (digest_index),
        .o_digest_last  (digest_last)
    );

    sm3_digest_checker digest_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (req_valid),
        .i_req_ready    (req_ready),
        .i_data_word    (req_data),
        .i_valid_bytes  (req_nbytes),
        .i_final_word   (req_final),
        .i_dig_valid    (dig_valid),
        .i_dig_ready    (dig_ready),
        .i_digest_word  (digest_word),
        .i_digest_index (digest_index),
        .i_digest_last  (digest_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input logic [31:0] w, input logic [2:0] nb, input logic fin);
        int unsigned gap;
        req_valid  <= 1'b1;
        req_data   <= w;
        req_nbytes <= nb;
        req_final  <= fin;
        @(posedge i_clk);
        while (!req_ready)
            @(posedge i_clk);
        words_sent++;
        gap = 0;
        if (!quiet_tail && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 6);
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_message(input int unsigned nwords, input logic [2:0] tail);
        for (int unsigned i = 0; i < nwords; i++)
            send_request(pick_word(), 3'($urandom_range(0, 7)), 1'b0);
        send_request(pick_word(), tail, 1'b1);
    endtask

    task automatic drain_digests();
        req_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
    endtask

    // receiver: short random stalls, one long hold-off, none in the tail
    initial begin
        int unsigned taken;
        int unsigned hold;
        bit          long_done;
        taken     = 0;
        long_done = 1'b0;
        forever begin
            hold = 0;
            if (!quiet_tail) begin
                if (!long_done && taken >= 120) begin
                    hold      = LONG_HOLD;
                    long_done = 1'b1;
                end else if ($urandom_range(0, 4) == 0) begin
                    hold = $urandom_range(1, 6);
                end
            end
            if (hold != 0) begin
                dig_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            dig_ready <= 1'b1;
            @(posedge i_clk);
            if (dig_valid && dig_ready)
                taken++;
        end
    end

    always @(posedge i_clk) begin
        if ((req_valid && req_ready) || (dig_valid && dig_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL sm3_hash_core");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned len;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty message, each tail byte count, counts above four
        send_request(32'h0000_0000, 3'd0, 1'b1);
        send_request(32'hffff_ffff, 3'd1, 1'b1);
        send_request(32'h6162_63ff, 3'd3, 1'b1);
        send_request(32'h8000_0001, 3'd2, 1'b1);
        send_request(32'hffff_ffff, 3'd4, 1'b1);
        send_request(32'h1234_5678, 3'd7, 1'b1);
        send_request(32'hdead_beef, 3'd5, 1'b1);
        // 64-byte message, padding needs a fresh block
        for (int unsigned i = 0; i < 15; i++)
            send_request((i % 2 == 0) ? 32'hffff_ffff : 32'h0000_0000, 3'(i), 1'b0);
        send_request(32'h0f0f_0f0f, 3'd4, 1'b1);
        drain_digests();

        while (words_sent < TARGET_WORDS) begin
            if (words_sent >= QUIET_FROM)
                quiet_tail = 1'b1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(0, 8);
                6, 7:             len = $urandom_range(12, 17);
                8:                len = $urandom_range(28, 33);
                default:          len = $urandom_range(0, 48);
            endcase
            send_message(len, 3'($urandom_range(0, 7)));
            if (!quiet_tail && $urandom_range(0, 9) == 0)
                drain_digests();
        end

        drain_digests();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS sm3_hash_core");
        else
            $display("FAIL sm3_hash_core");
        $finish;
    end

endmodule

/* filelist.f */
design/sm3_pkg.sv
design/sm3_compress.sv
design/sm3_hash_core.sv
sim/sm3_digest_checker.sv
sim/testbench.sv
